// ===== design/dmcmc_pkg.sv =====
// Shared constants, types and the clearing-sweep state encoding for the cache miss counter.
`default_nettype none
package dmcmc_pkg;

    // Cache geometry; LINE_COUNT is a power of two
    localparam int LINE_COUNT  = 1024;
    localparam int OFFSET_BITS = 5;
    localparam int ADDR_BITS   = 32;
    localparam int ADDR_W      = 32;
    localparam int INDEX_W     = $clog2(LINE_COUNT);
    localparam int TAG_W       = ADDR_BITS - OFFSET_BITS - INDEX_W;
    localparam int COUNT_W     = 32;

    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [TAG_W-1:0]   t_tag;
    typedef logic [COUNT_W-1:0] t_count;

    // One tag store entry
    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_entry;

    // Write request into the tag store
    typedef struct packed {
        logic   en;
        t_index idx;
        t_tag   tag;
    } t_wr_req;

    // Read request into the tag store
    typedef struct packed {
        logic   en;
        t_index idx;
    } t_rd_req;

    // Tag store sweep state
    typedef enum logic {
        ST_CLEAR,
        ST_READY
    } t_store_state;

endpackage
`default_nettype wire

// ===== design/direct_mapped_cache_miss_counter.sv =====
// Top level of the direct-mapped cache tag check with access and miss counters.
// One address word is taken per cycle unless the output stalls, and gives one result
// word: the tag memory is read in the accept cycle, and the lookup stage that follows
// compares the tag, writes the line back on a miss and updates the counters, which load the output
// register. A miss write to the same line as the following word is forwarded, so
// words may follow each other in every cycle; throughput is one word a cycle while results
// are taken, limited by the single read and single write port of the tag memory. After reset
// ready stays low while the memory is swept to clear the valid bits of all 1024 lines.
`default_nettype none
module direct_mapped_cache_miss_counter (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [31:0]           i_address,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_hit,
    output dmcmc_pkg::t_count          o_access_count,
    output dmcmc_pkg::t_count          o_miss_count
);
    import dmcmc_pkg::*;

    t_rd_req rd_req;
    t_wr_req wr_req;
    t_entry  rd_entry;
    t_entry  eff_entry;
    logic    store_ready;
    logic    accept;
    logic    lk_adv;
    logic    lk_hit;
    t_index  in_idx;
    t_tag    in_tag;

    logic    r_lk_vld;
    logic    n_lk_vld;
    t_index  r_lk_idx;
    t_tag    r_lk_tag;
    logic    r_fwd;
    t_tag    r_fwd_tag;
    logic    r_out_vld;
    logic    n_out_vld;
    logic    r_out_hit;

    // Split the address into line index and tag
    assign in_idx = i_address[OFFSET_BITS +: INDEX_W];
    assign in_tag = i_address[ADDR_BITS-1 -: TAG_W];

    // Handshake and stage advance
    assign lk_adv  = r_lk_vld && (!r_out_vld || i_ready);
    assign o_ready = store_ready && (!r_lk_vld || lk_adv);
    assign accept  = i_valid && o_ready;

    assign rd_req = '{en: accept, idx: in_idx};

    // Take the forwarded line when the previous word just filled it
    assign eff_entry = r_fwd ? t_entry'{valid: 1'b1, tag: r_fwd_tag} : rd_entry;
    assign lk_hit    = eff_entry.valid && (eff_entry.tag == r_lk_tag);

    assign wr_req = '{en: lk_adv && !lk_hit, idx: r_lk_idx, tag: r_lk_tag};

    dmcmc_tag_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (rd_req),
        .i_wr       (wr_req),
        .o_rd_entry (rd_entry),
        .o_ready    (store_ready)
    );

    dmcmc_counters u_cnt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (lk_adv),
        .i_miss         (!lk_hit),
        .o_access_count (o_access_count),
        .o_miss_count   (o_miss_count)
    );

    // Next valid flags of lookup and output stages
    always_comb begin
        n_lk_vld = r_lk_vld;
        if (accept) begin
            n_lk_vld = 1'b1;
        end else if (lk_adv) begin
            n_lk_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (lk_adv) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_lk_vld  <= n_lk_vld;
            r_out_vld <= n_out_vld;
            if (accept) begin
                r_fwd <= lk_adv && !lk_hit && (in_idx == r_lk_idx);
            end
        end
    end

    // Hold the lookup word and the forwarded tag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lk_idx  <= in_idx;
            r_lk_tag  <= in_tag;
            r_fwd_tag <= r_lk_tag;
        end
        if (lk_adv) begin
            r_out_hit <= lk_hit;
        end
    end

    assign o_valid = r_out_vld;
    assign o_hit   = r_out_hit;

    // No word enters while the sweep is still running
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !store_ready |-> !accept)
        else $error("word accepted during clearing sweep");

    // Misses never outrun accesses
    a_miss_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_miss_count <= o_access_count))
        else $error("miss count above access count");

    // A word just filled into a line hits when the next word has the same index and tag
    a_fwd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd && r_lk_vld && (r_fwd_tag == r_lk_tag)) |-> lk_hit)
        else $error("forwarded line failed to hit");

    // A miss result carries a non-zero miss count
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_miss_count != '0))
        else $error("miss shown without count");

endmodule
`default_nettype wire

// ===== design/dmcmc_tag_store.sv =====
// Tag store: valid and tag memory with a clearing sweep after reset.
`default_nettype none
module dmcmc_tag_store (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dmcmc_pkg::t_rd_req i_rd,
    input  wire dmcmc_pkg::t_wr_req i_wr,
    output dmcmc_pkg::t_entry     o_rd_entry,
    output logic                  o_ready
);
    import dmcmc_pkg::*;

    t_entry       r_mem [LINE_COUNT];
    t_entry       r_rd_entry;
    t_store_state r_state;
    t_store_state n_state;
    t_index       r_clr_idx;
    t_index       n_clr_idx;
    logic         clr_last;
    logic         clr_en;

    assign clr_last = (r_clr_idx == t_index'(LINE_COUNT - 1));

    // Next state of the sweep
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + t_index'(1);
                if (clr_last) begin
                    n_state = ST_READY;
                end
            end
            ST_READY: begin
                n_clr_idx = r_clr_idx;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sweep
    always_comb begin
        clr_en  = 1'b0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: clr_en  = 1'b1;
            ST_READY: o_ready = 1'b1;
            default: begin
                clr_en  = 1'b0;
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    // Write port: sweep first, then line fills
    always_ff @(posedge i_clk) begin
        if (clr_en) begin
            r_mem[r_clr_idx] <= '{valid: 1'b0, tag: '0};
        end else if (i_wr.en) begin
            r_mem[i_wr.idx] <= '{valid: 1'b1, tag: i_wr.tag};
        end
    end

    // Read port, registered, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_entry <= r_mem[i_rd.idx];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule
`default_nettype wire

// ===== design/dmcmc_counters.sv =====
// Saturating access and miss counters.
`default_nettype none
module dmcmc_counters (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_miss,
    output dmcmc_pkg::t_count   o_access_count,
    output dmcmc_pkg::t_count   o_miss_count
);
    import dmcmc_pkg::*;

    t_count r_acc;
    t_count n_acc;
    t_count r_miss;
    t_count n_miss;

    // Advance each counter, hold at full scale
    always_comb begin
        n_acc  = r_acc;
        n_miss = r_miss;
        if (i_step) begin
            if (r_acc != '1) begin
                n_acc = r_acc + t_count'(1);
            end
            if (i_miss && (r_miss != '1)) begin
                n_miss = r_miss + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_miss <= '0;
        end else begin
            r_acc  <= n_acc;
            r_miss <= n_miss;
        end
    end

    assign o_access_count = r_acc;
    assign o_miss_count   = r_miss;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the direct-mapped cache tag check and its access and miss counters.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmcmc_pkg::*;

    localparam int TAG_LSB        = OFFSET_BITS + INDEX_W;
    localparam int HOLDOFF_CYCLES = 8;
    localparam int RANDOM_WORDS   = 430;
    localparam int DIRECTED_WORDS = 20;
    localparam t_count COUNT_TOP  = '1;

    // Hand-picked addresses: address extremes, offset-only changes, evictions on
    // line 0 and line 1023, same line with alternating tags back to back
    localparam logic [ADDR_W-1:0] DIRECTED_ADDR [DIRECTED_WORDS] = '{
        32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
        32'h0000_8000, 32'h0000_0000, 32'h0000_8000, 32'h0000_8004,
        32'h0000_7FE0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0020,
        32'h0000_0040, 32'h8000_0000, 32'h8000_001F, 32'h7FFF_FFFF
    };

    typedef struct packed {
        logic   hit;
        t_count accesses;
        t_count misses;
    } lookup_result_t;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic [ADDR_W-1:0] i_address = '0;
    logic              i_ready   = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_hit;
    t_count            o_access_count;
    t_count            o_miss_count;

    // Predictor state: our own copy of the tag store and counters
    bit                line_live [LINE_COUNT];
    t_tag              line_owner [LINE_COUNT];
    t_count            access_tally = '0;
    t_count            miss_tally   = '0;

    logic [ADDR_W-1:0] address_backlog [$];
    lookup_result_t    expected_lookups [$];

    // Address generator state
    logic [ADDR_W-1:0] recent_addr [8];
    t_tag              hot_tags [4];
    logic [ADDR_W-1:0] stream_addr;

    int unsigned       idle_pct  = 0;
    int unsigned       stall_pct = 0;
    int                fail_count  = 0;
    int                words_seen  = 0;
    int                hits_seen   = 0;

    direct_mapped_cache_miss_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_address      (i_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_access_count (o_access_count),
        .o_miss_count   (o_miss_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Look one address up in the predicted tag store and queue the result word
    function automatic void lookup_line(logic [ADDR_W-1:0] addr);
        t_index         idx;
        t_tag           tag;
        lookup_result_t res;
        idx = addr[OFFSET_BITS +: INDEX_W];
        tag = addr[TAG_LSB +: TAG_W];
        res.hit = line_live[idx] && (line_owner[idx] == tag);
        if (!res.hit) begin
            line_live[idx]  = 1'b1;
            line_owner[idx] = tag;
            if (miss_tally != COUNT_TOP) miss_tally = miss_tally + 1'b1;
        end
        if (access_tally != COUNT_TOP) access_tally = access_tally + 1'b1;
        res.accesses = access_tally;
        res.misses   = miss_tally;
        expected_lookups.push_back(res);
    endfunction

    // Draw an address with locality: revisits, conflicts on one line, streams, noise
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       roll;
        logic [ADDR_W-1:0] a;
        roll = $urandom_range(99);
        if (roll < 35) begin
            a = recent_addr[$urandom_range(7)];
            a[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
        end else if (roll < 60) begin
            a = recent_addr[$urandom_range(7)];
            a[TAG_LSB +: TAG_W] = hot_tags[$urandom_range(3)];
        end else if (roll < 80) begin
            if ($urandom_range(15) == 0) stream_addr = $urandom;
            stream_addr = stream_addr + 4;
            a = stream_addr;
        end else begin
            a = $urandom;
        end
        recent_addr[$urandom_range(7)] = a;
        return a;
    endfunction

    // Driver: predict on acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) lookup_line(i_address);
            if (!i_valid || o_ready) begin
                if (address_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid   <= 1'b1;
                    i_address <= address_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        lookup_result_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("unexpected result word: hit %0d, accesses %0d, misses %0d",
                           o_hit, o_access_count, o_miss_count);
                    fail_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    words_seen++;
                    if (want.hit) hits_seen++;
                    if (o_hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, got %0d", want.hit, o_hit);
                        fail_count++;
                    end
                    if (o_access_count !== want.accesses) begin
                        $error("access_count mismatch: expected %0d, got %0d",
                               want.accesses, o_access_count);
                        fail_count++;
                    end
                    if (o_miss_count !== want.misses) begin
                        $error("miss_count mismatch: expected %0d, got %0d",
                               want.misses, o_miss_count);
                        fail_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hold the sender until every queued word is taken and every result is back
    task automatic wait_drained();
        while (address_backlog.size() != 0 || i_valid || expected_lookups.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(int unsigned tx_idle, int unsigned rx_stall);
        idle_pct  = tx_idle;
        stall_pct = rx_stall;
        for (int n = 0; n < RANDOM_WORDS; n++) address_backlog.push_back(pick_address());
        wait_drained();
    endtask

    // Stimulus: directed words, then random phases under varying back-pressure
    initial begin
        foreach (line_live[k]) line_live[k] = 1'b0;
        hot_tags[0] = '0;
        hot_tags[1] = '1;
        hot_tags[2] = TAG_W'($urandom);
        hot_tags[3] = TAG_W'($urandom);
        foreach (recent_addr[k]) recent_addr[k] = $urandom;
        stream_addr = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ADDR[k]) address_backlog.push_back(DIRECTED_ADDR[k]);
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(18, 18);

        // Let any stray result word surface before closing
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);

        $display("tb: %0d result words checked, %0d hits and %0d misses predicted,",
                 words_seen, hits_seen, words_seen - hits_seen);
        $display("tb: directed corners plus four random phases with sender and receiver gaps");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Timeout well past the slowest legal run, clearing sweep included
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
